// File: rtl/core/ppct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppct_pkg
// shared types and constants of the particle plane contact test unit
// ----------------------------------------------------------------------------
package ppct_pkg;

    localparam int PLANES     = 16;
    localparam int IDX_W      = $clog2(PLANES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CW         = 24;
    localparam int FRAC_BITS  = 8;
    localparam int DW         = CW + 1;
    localparam int PW         = 2 * DW;
    localparam int NW         = PW + 2;

    // one unit in the fixed point format
    localparam logic signed [DW-1:0] ONE_UNIT = DW'(1) <<< FRAC_BITS;

    // field selector codes of a write word
    localparam logic [3:0] FLD_XLOW  = 4'd0;
    localparam logic [3:0] FLD_XHIGH = 4'd1;
    localparam logic [3:0] FLD_ZLOW  = 4'd2;
    localparam logic [3:0] FLD_ZHIGH = 4'd3;
    localparam logic [3:0] FLD_YA    = 4'd4;
    localparam logic [3:0] FLD_YB    = 4'd5;
    localparam logic [3:0] FLD_SLOPE = 4'd6;
    localparam logic [3:0] FLD_PUSHX = 4'd7;
    localparam logic [3:0] FLD_PUSHZ = 4'd8;

    // slope axis codes
    localparam logic [1:0] AX_FLAT = 2'd0;
    localparam logic [1:0] AX_X    = 2'd1;
    localparam logic [1:0] AX_Z    = 2'd2;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [CW-1:0] x_low;
        logic [CW-1:0] x_high;
        logic [CW-1:0] z_low;
        logic [CW-1:0] z_high;
        logic [CW-1:0] y_first;
        logic [CW-1:0] y_second;
        logic [1:0]    axis;
        logic [CW-1:0] push_x;
        logic [CW-1:0] push_z;
    } plane_t;

    typedef struct packed {
        logic          valid;
        logic          last;
        logic [CW-1:0] pos_x;
        logic [CW-1:0] pos_y;
        logic [CW-1:0] pos_z;
    } probe_t;

    typedef struct packed {
        logic          valid;
        logic          last;
        logic          match;
        logic [CW-1:0] push_x;
        logic [CW-1:0] push_z;
    } verdict_t;

endpackage

// File: rtl/core/ppct_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppct_table
// plane table: one field written per word, one entry read per cycle
// ----------------------------------------------------------------------------
module ppct_table
    import ppct_pkg::*;
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_index,
    input  logic [3:0]          wr_field,
    input  logic [CW-1:0]       wr_value,
    input  logic [IDX_W-1:0]    rd_index,
    output plane_t              rd_plane
);

    plane_t planes_reg [PLANES];
    plane_t rd_plane_reg;
    logic [1:0] slope_code;

    // slope code clamped to the legal range
    always_comb
    begin
        if (wr_value[CW-1])
            slope_code = AX_FLAT;
        else if (wr_value > CW'(2))
            slope_code = AX_Z;
        else
            slope_code = wr_value[1:0];
    end

    // field write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            unique case (wr_field)
                FLD_XLOW:  planes_reg[wr_index].x_low    <= wr_value;
                FLD_XHIGH: planes_reg[wr_index].x_high   <= wr_value;
                FLD_ZLOW:  planes_reg[wr_index].z_low    <= wr_value;
                FLD_ZHIGH: planes_reg[wr_index].z_high   <= wr_value;
                FLD_YA:    planes_reg[wr_index].y_first  <= wr_value;
                FLD_YB:    planes_reg[wr_index].y_second <= wr_value;
                FLD_SLOPE: planes_reg[wr_index].axis     <= slope_code;
                FLD_PUSHX: planes_reg[wr_index].push_x   <= wr_value;
                FLD_PUSHZ: planes_reg[wr_index].push_z   <= wr_value;
                default:   ;
            endcase
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_plane_reg <= planes_reg[rd_index];
    end

    assign rd_plane = rd_plane_reg;

endmodule

// File: rtl/core/ppct_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppct_eval
// four stage contact test of one plane against one particle
// ----------------------------------------------------------------------------
module ppct_eval
    import ppct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  plane_t   plane,
    input  probe_t   probe,
    output verdict_t verdict
);

    // stage 1 signals
    logic signed [DW-1:0] px, py, pz, lo, hi, pp, ya_e;
    logic                 box_ok, flat_ok, sloped;

    logic                 v1_reg, l1_reg, box1_reg, flat1_reg, slope1_reg, spok1_reg;
    logic [CW-1:0]        pushx1_reg, pushz1_reg;
    logic signed [CW-1:0] ya1_reg, yb1_reg;
    logic signed [DW-1:0] d1_reg, d2_reg, span1_reg, a1_reg, b1_reg;

    // stage 2 signals
    logic                 v2_reg, l2_reg, box2_reg, flat2_reg, slope2_reg, spok2_reg;
    logic [CW-1:0]        pushx2_reg, pushz2_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, as_reg, bs_reg;
    logic signed [DW-1:0] span2_reg;

    // stage 3 signals
    logic                 v3_reg, l3_reg, box3_reg, flat3_reg, slope3_reg, spok3_reg;
    logic [CW-1:0]        pushx3_reg, pushz3_reg;
    logic signed [NW-1:0] num_reg, as3_reg, bs3_reg, span3_reg;

    // stage 4 signals
    logic                 cond, match_next;
    logic                 v4_reg, l4_reg, match4_reg;
    logic [CW-1:0]        pushx4_reg, pushz4_reg;

    // stage 1: box test, axis selection, distances
    always_comb
    begin
        px   = {plane.x_low[CW-1] ^ plane.x_low[CW-1], probe.pos_x} ^
               {probe.pos_x[CW-1], {CW{1'b0}}};
        py   = {probe.pos_y[CW-1], probe.pos_y};
        pz   = {probe.pos_z[CW-1], probe.pos_z};
        ya_e = {plane.y_first[CW-1], plane.y_first};
        box_ok = ($signed(probe.pos_x) >= $signed(plane.x_low))  &&
                 ($signed(probe.pos_x) <= $signed(plane.x_high)) &&
                 ($signed(probe.pos_z) >= $signed(plane.z_low))  &&
                 ($signed(probe.pos_z) <= $signed(plane.z_high));
        flat_ok = (py >= ya_e - ONE_UNIT) && (py <= ya_e + ONE_UNIT);
        sloped  = (plane.axis == AX_X) || (plane.axis == AX_Z);
        if (plane.axis == AX_X)
        begin
            lo = {plane.x_low[CW-1], plane.x_low};
            hi = {plane.x_high[CW-1], plane.x_high};
            pp = px;
        end
        else
        begin
            lo = {plane.z_low[CW-1], plane.z_low};
            hi = {plane.z_high[CW-1], plane.z_high};
            pp = pz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= probe.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        l1_reg     <= probe.last;
        box1_reg   <= box_ok;
        flat1_reg  <= flat_ok;
        slope1_reg <= sloped;
        spok1_reg  <= (hi - lo) > DW'(0);
        pushx1_reg <= plane.push_x;
        pushz1_reg <= plane.push_z;
        ya1_reg    <= plane.y_first;
        yb1_reg    <= plane.y_second;
        d1_reg     <= hi - pp;
        d2_reg     <= pp - lo;
        span1_reg  <= hi - lo;
        a1_reg     <= py - ONE_UNIT;
        b1_reg     <= py + ONE_UNIT;
    end

    // stage 2: products for the numerator and the scaled height bounds
    always_ff @(posedge clk)
    begin
        l2_reg     <= l1_reg;
        box2_reg   <= box1_reg;
        flat2_reg  <= flat1_reg;
        slope2_reg <= slope1_reg;
        spok2_reg  <= spok1_reg;
        pushx2_reg <= pushx1_reg;
        pushz2_reg <= pushz1_reg;
        p1_reg     <= PW'($signed({ya1_reg[CW-1], ya1_reg}) * d1_reg);
        p2_reg     <= PW'($signed({yb1_reg[CW-1], yb1_reg}) * d2_reg);
        as_reg     <= PW'(a1_reg * span1_reg);
        bs_reg     <= PW'(b1_reg * span1_reg);
        span2_reg  <= span1_reg;
    end

    // stage 3: numerator sum
    always_ff @(posedge clk)
    begin
        l3_reg     <= l2_reg;
        box3_reg   <= box2_reg;
        flat3_reg  <= flat2_reg;
        slope3_reg <= slope2_reg;
        spok3_reg  <= spok2_reg;
        pushx3_reg <= pushx2_reg;
        pushz3_reg <= pushz2_reg;
        num_reg    <= NW'(p1_reg) + NW'(p2_reg);
        as3_reg    <= NW'(as_reg);
        bs3_reg    <= NW'(bs_reg);
        span3_reg  <= NW'(span2_reg);
    end

    // stage 4: truncated quotient within one unit, compared without a divide
    always_comb
    begin
        if (!num_reg[NW-1])
            cond = (num_reg >= as3_reg) && (num_reg < bs3_reg + span3_reg);
        else
            cond = (num_reg > as3_reg - span3_reg) && (num_reg <= bs3_reg);
        match_next = box3_reg && (slope3_reg ? (spok3_reg && cond) : flat3_reg);
    end

    always_ff @(posedge clk)
    begin
        l4_reg     <= l3_reg;
        match4_reg <= match_next;
        pushx4_reg <= pushx3_reg;
        pushz4_reg <= pushz3_reg;
    end

    // verdict word
    always_comb
    begin
        verdict.valid  = v4_reg;
        verdict.last   = l4_reg;
        verdict.match  = match4_reg;
        verdict.push_x = pushx4_reg;
        verdict.push_z = pushz4_reg;
    end

endmodule

// File: rtl/core/particle_plane_contact_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_plane_contact_test_unit
// finds the first plane of a table that a particle touches
// ----------------------------------------------------------------------------
// usage
// - s_* carries request words: s_tuser 0 writes one plane field, 1 queries a
//   particle position. a write word gives no result.
// - a query scans entries 0 to n-1, n = plane_count limited to 16, feeding one
//   plane per cycle into a five stage test pipeline (table read, box and
//   distances, products, sum, compare); the first touching plane wins.
// - the next request word is taken once the result of a query is in the output
//   register; a write word holds up no later word.
// - m_* carries one result word per query: m_tuser is hit, m_tdata the push
//   vector, zero on a miss. it holds until m_tready; while it is stalled,
//   write words still go in and one further query runs up to its result,
//   then s_tready stays low.
// - cfg_* writes plane_count, taken at any time, used only while idle.
// - reset clears plane_count and all control state; table contents stay
//   undefined until written.
// ----------------------------------------------------------------------------
module particle_plane_contact_test_unit
    import ppct_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // entry_index, field_select, field_value, pos_x, pos_y, pos_z
    input  logic          s_tuser,   // req_type
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,   // push_x, push_z
    output logic          m_tuser,   // hit
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [4:0]    cfg_data   // plane_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [4:0]       count_reg;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]    qx_reg, qy_reg, qz_reg;
    logic             found_reg, found_next;
    logic [CW-1:0]    fx_reg, fx_next, fz_reg, fz_next;
    logic             issue, issue_last, rd_valid_reg, rd_last_reg;
    logic             out_valid_reg, out_hit_reg;
    logic [47:0]      out_data_reg;
    logic             accept, wr_en, load_out;
    plane_t           plane;
    probe_t           probe;
    verdict_t         verdict;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign wr_en     = accept && (s_tuser == REQ_WRITE);
    assign issue      = (state_reg == ST_SCAN);
    assign issue_last = ({1'b0, idx_reg} + CNT_W'(1)) == n_reg;
    assign load_out   = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    ppct_table u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_index (s_tdata[3:0]),
        .wr_field (s_tdata[7:4]),
        .wr_value (s_tdata[31:8]),
        .rd_index (idx_reg),
        .rd_plane (plane)
    );

    // probe travels beside the plane read out of the table
    always_comb
    begin
        probe.valid = rd_valid_reg;
        probe.last  = rd_last_reg;
        probe.pos_x = qx_reg;
        probe.pos_y = qy_reg;
        probe.pos_z = qz_reg;
    end

    ppct_eval u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .plane   (plane),
        .probe   (probe),
        .verdict (verdict)
    );

    // scan sequencer and first hit capture
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        fx_next    = fx_reg;
        fz_next    = fz_reg;
        if (verdict.valid && verdict.match && !found_reg)
        begin
            found_next = 1'b1;
            fx_next    = verdict.push_x;
            fz_next    = verdict.push_z;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == REQ_QUERY))
                begin
                    n_next     = (count_reg > 5'(PLANES)) ? CNT_W'(PLANES) : CNT_W'(count_reg);
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = (count_reg == 5'd0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_last)
                    state_next = ST_WAIT;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_WAIT:
            begin
                if (verdict.valid && verdict.last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            found_reg    <= found_next;
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        fx_reg      <= fx_next;
        fz_reg      <= fz_next;
        rd_last_reg <= issue_last;
        if (accept)
        begin
            qx_reg <= s_tdata[55:32];
            qy_reg <= s_tdata[79:56];
            qz_reg <= s_tdata[103:80];
        end
        if (load_out)
        begin
            out_hit_reg  <= found_reg;
            out_data_reg <= found_reg ? {fz_reg, fx_reg} : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

endmodule

// File: rtl/core/ppct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppct_checker
// port level checks of the contact test unit, bound to the top level
// ----------------------------------------------------------------------------
module ppct_checker
    import ppct_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          s_tuser,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [47:0]   m_tdata,
    input logic          m_tuser
);

    // result word holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a miss carries a zero push
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 48'd0)
        else $error("miss with non-zero push");

    // a query blocks the input while it scans
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == REQ_QUERY) |=> !s_tready)
        else $error("word taken during a query");

endmodule

bind particle_plane_contact_test_unit ppct_checker u_ppct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/particle_plane_contact_test_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_plane_contact_test_unit_test
// self-checking testbench of the particle plane contact test unit
// ----------------------------------------------------------------------------
// fills the plane table, then sends write and query words with random gaps on
// both stream sides. a plane table model inside the bench predicts the result
// word of each query; a monitor checks every result word in order.
// ----------------------------------------------------------------------------
module particle_plane_contact_test_unit_test;
    import ppct_pkg::*;

    typedef struct {
        logic          hit;
        logic [CW-1:0] push_x;
        logic [CW-1:0] push_z;
    } contact_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [103:0]  s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [47:0]   m_tdata;
    logic          m_tuser;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [4:0]    cfg_data;

    // plane table model
    logic signed [CW-1:0] tbl_xl [PLANES];
    logic signed [CW-1:0] tbl_xh [PLANES];
    logic signed [CW-1:0] tbl_zl [PLANES];
    logic signed [CW-1:0] tbl_zh [PLANES];
    logic signed [CW-1:0] tbl_ya [PLANES];
    logic signed [CW-1:0] tbl_yb [PLANES];
    logic [1:0]           tbl_axis [PLANES];
    logic signed [CW-1:0] tbl_px [PLANES];
    logic signed [CW-1:0] tbl_pz [PLANES];
    logic [4:0]           search_count;

    contact_t contact_q[$];
    int       fail_count;
    int       rx_hold;
    bit       steady;

    particle_plane_contact_test_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("particle_plane_contact_test_unit regression: fail");
        $finish;
    end

    // height of a plane at the particle; returns zero if the plane has no valid span
    function automatic bit plane_height(int k, logic signed [CW-1:0] px,
                                        logic signed [CW-1:0] pz, output longint h);
        longint lo;
        longint hi;
        longint p;
        longint ya;
        longint yb;
        h  = tbl_ya[k];
        ya = tbl_ya[k];
        yb = tbl_yb[k];
        if (tbl_axis[k] == AX_X)
        begin
            lo = tbl_xl[k];
            hi = tbl_xh[k];
            p  = px;
        end
        else if (tbl_axis[k] == AX_Z)
        begin
            lo = tbl_zl[k];
            hi = tbl_zh[k];
            p  = pz;
        end
        else
            return 1'b1;
        if (hi - lo <= 0)
            return 1'b0;
        h = (ya * (hi - p) + yb * (p - lo)) / (hi - lo);
        return 1'b1;
    endfunction

    // first touching plane of the searched entries
    function automatic contact_t find_contact(logic signed [CW-1:0] px,
                                              logic signed [CW-1:0] py,
                                              logic signed [CW-1:0] pz);
        contact_t c;
        int       n;
        longint   h;
        longint   y;
        c = '{1'b0, '0, '0};
        n = (search_count > PLANES) ? PLANES : search_count;
        y = py;
        for (int k = 0; k < n; k++)
        begin
            if (px < tbl_xl[k] || px > tbl_xh[k] || pz < tbl_zl[k] || pz > tbl_zh[k])
                continue;
            if (!plane_height(k, px, pz, h))
                continue;
            if (y >= h - 256 && y <= h + 256)
            begin
                c = '{1'b1, tbl_px[k], tbl_pz[k]};
                return c;
            end
        end
        return c;
    endfunction

    // model update for one accepted request word
    task automatic apply_word(logic kind, logic [103:0] d);
        logic [3:0]           e;
        logic signed [CW-1:0] v;
        e = d[3:0];
        v = d[31:8];
        if (kind == REQ_QUERY)
            contact_q.push_back(find_contact(d[55:32], d[79:56], d[103:80]));
        else
            case (d[7:4])
                FLD_XLOW:  tbl_xl[e] = v;
                FLD_XHIGH: tbl_xh[e] = v;
                FLD_ZLOW:  tbl_zl[e] = v;
                FLD_ZHIGH: tbl_zh[e] = v;
                FLD_YA:    tbl_ya[e] = v;
                FLD_YB:    tbl_yb[e] = v;
                FLD_SLOPE: tbl_axis[e] = (v < 0) ? AX_FLAT : ((v > 2) ? AX_Z : v[1:0]);
                FLD_PUSHX: tbl_px[e] = v;
                FLD_PUSHZ: tbl_pz[e] = v;
                default: ;
            endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one request word and wait until it is taken
    task automatic send_word(logic kind, logic [103:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_word(kind, d);
    endtask

    task automatic write_field(int e, logic [3:0] f, logic [CW-1:0] v);
        send_word(REQ_WRITE, {72'd0, v, f, 4'(e)});
    endtask

    task automatic query(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
        send_word(REQ_QUERY, {pz, py, px, 32'd0});
    endtask

    // wait for every expected word, then for the pipeline to empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (contact_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_count(logic [4:0] n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        search_count = n;
    endtask

    // random plane with a small box somewhere in the coordinate range
    task automatic write_plane(int e);
        int cx;
        int cz;
        int w;
        int base;
        cx   = $urandom_range(0, 2**21) - 2**20;
        cz   = $urandom_range(0, 2**21) - 2**20;
        base = $urandom_range(0, 2**21) - 2**20;
        w    = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2**16) : $urandom_range(1, 2048);
        write_field(e, FLD_XLOW, CW'(cx - w));
        write_field(e, FLD_XHIGH, CW'(cx + w));
        w = $urandom_range(1, 4096);
        write_field(e, FLD_ZLOW, CW'(cz - w));
        write_field(e, FLD_ZHIGH, CW'(cz + w));
        write_field(e, FLD_YA, CW'(base));
        write_field(e, FLD_YB, CW'(base + $urandom_range(0, 8192) - 4096));
        write_field(e, FLD_SLOPE, CW'($urandom_range(0, 2)));
        write_field(e, FLD_PUSHX, CW'($urandom));
        write_field(e, FLD_PUSHZ, CW'($urandom));
    endtask

    // query near a chosen plane, or anywhere now and then
    task automatic random_query();
        int     k;
        longint px;
        longint pz;
        longint h;
        k = $urandom_range(0, PLANES - 1);
        if ($urandom_range(0, 9) < 2)
        begin
            query(CW'($urandom), CW'($urandom), CW'($urandom));
            return;
        end
        px = tbl_xl[k];
        pz = tbl_zl[k];
        if (tbl_xh[k] >= tbl_xl[k])
            px += $urandom_range(0, tbl_xh[k] - tbl_xl[k]);
        if (tbl_zh[k] >= tbl_zl[k])
            pz += $urandom_range(0, tbl_zh[k] - tbl_zl[k]);
        if ($urandom_range(0, 9) == 0)
            px += $urandom_range(0, 1) ? 1 : -1;
        void'(plane_height(k, CW'(px), CW'(pz), h));
        query(CW'(px), CW'(h + $urandom_range(0, 700) - 350), CW'(pz));
    endtask

    task automatic random_word();
        int e;
        int r;
        r = $urandom_range(0, 99);
        e = $urandom_range(0, PLANES - 1);
        if (r < 75)
            random_query();
        else if (r < 85)
            write_field(e, 4'(FLD_PUSHX + $urandom_range(0, 1)), CW'($urandom));
        else if (r < 90)
            write_field(e, 4'($urandom_range(9, 15)), CW'($urandom));
        else if (r < 95)
            write_field(e, FLD_SLOPE,
                        CW'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3)));
        else
            write_plane(e);
    endtask

    // --- test tasks ---

    task automatic test_fill_table();
        query(24'h000100, 24'h000000, 24'h000100);
        for (int e = 0; e < PLANES; e++)
            write_plane(e);
        set_count(5'd16);
    endtask

    task automatic test_special_cases();
        // slope codes out of range and unknown fields
        write_field(0, FLD_SLOPE, -24'sd5);
        write_field(1, FLD_SLOPE, 24'd7);
        write_field(2, 4'd9, 24'hFFFFFF);
        write_field(2, 4'd15, 24'h123456);
        // zero span along its slope axis on entry 1
        write_field(1, FLD_ZHIGH, tbl_zl[1]);
        query(tbl_xl[1], tbl_ya[1], tbl_zl[1]);
        // empty box on entry 2
        write_field(2, FLD_XHIGH, CW'(tbl_xl[2] - 1));
        query(tbl_xl[2], tbl_ya[2], tbl_zl[2]);
        // flat plane on entry 0 at the height limits
        query(tbl_xl[0], CW'(tbl_ya[0] + 256), tbl_zl[0]);
        query(tbl_xh[0], CW'(tbl_ya[0] - 256), tbl_zh[0]);
        query(tbl_xh[0], CW'(tbl_ya[0] + 257), tbl_zh[0]);
        // a count above the table size, then a zero count
        set_count(5'd31);
        query(tbl_xl[3], tbl_ya[3], tbl_zl[3]);
        set_count(5'd0);
        query(tbl_xl[3], tbl_ya[3], tbl_zl[3]);
        set_count(5'd16);
    endtask

    task automatic test_field_extremes();
        // plane 15 covering the whole space, push words at the extremes
        write_field(15, FLD_XLOW, 24'h800000);
        write_field(15, FLD_XHIGH, 24'h7FFFFF);
        write_field(15, FLD_ZLOW, 24'h800000);
        write_field(15, FLD_ZHIGH, 24'h7FFFFF);
        write_field(15, FLD_SLOPE, CW'(AX_FLAT));
        write_field(15, FLD_YA, 24'h7FFF00);
        write_field(15, FLD_PUSHX, 24'h7FFFFF);
        write_field(15, FLD_PUSHZ, 24'h800000);
        query(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
        query(24'h800000, 24'h800000, 24'h7FFFFF);
        query(24'h000000, 24'h7FFE00, 24'h000000);
    endtask

    task automatic test_backpressure();
        // receiver holds off, sender keeps offering until the unit stalls
        rx_hold = 300;
        steady  = 1'b1;
        repeat (12) random_query();
        steady = 1'b0;
        drain();
        repeat (6) random_query();
    endtask

    task automatic test_random();
        logic [4:0] counts [8] = '{5'd16, 5'd1, 5'd31, 5'd7, 5'd0, 5'd16, 5'd12, 5'd16};
        foreach (counts[p])
        begin
            set_count(counts[p]);
            steady = (p == 5);
            repeat (70) random_word();
        end
        steady = 1'b0;
    endtask

    // receiver: random stalls, and a long hold when asked
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall    = steady ? 0 : pick_gap();
                m_tready <= (stall == 0);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        contact_t c;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (contact_q.size() == 0)
            begin
                $error("unexpected result word hit=%0b push=%h", m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                c = contact_q.pop_front();
                if (m_tuser !== c.hit)
                begin
                    $error("hit expected %0b actual %0b", c.hit, m_tuser);
                    fail_count++;
                end
                if (m_tdata[23:0] !== c.push_x)
                begin
                    $error("push_x expected %h actual %h", c.push_x, m_tdata[23:0]);
                    fail_count++;
                end
                if (m_tdata[47:24] !== c.push_z)
                begin
                    $error("push_z expected %h actual %h", c.push_z, m_tdata[47:24]);
                    fail_count++;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        fail_count   = 0;
        rx_hold      = 0;
        steady       = 1'b0;
        search_count = '0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = REQ_WRITE;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_table();
        test_special_cases();
        test_field_extremes();
        test_backpressure();
        test_random();
        drain();

        if (fail_count == 0 && contact_q.size() == 0)
            $display("particle_plane_contact_test_unit regression: pass");
        else
            $display("particle_plane_contact_test_unit regression: fail");
        $finish;
    end

endmodule
